// ----- rtl/sito_pkg.sv -----
// Package for the strided index to offset block.
// Holds widths, register indexes, the division stage type and the
// shift-subtract step function. No dependencies.
package sito_pkg;

   localparam int DIMS_MAX       = 4;
   localparam int SIZE_W         = 16;
   localparam int STEP_W         = 32;
   localparam int IDX_W          = 32;
   localparam int PROD_W         = SIZE_W + STEP_W;
   localparam int SUM_W          = PROD_W + 2;
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = IDX_W / BITS_PER_STAGE;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int DIM_SEL_W      = 2;
   localparam int RSP_DATA_W     = 40;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_DIM3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DIM0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DIM1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DIM2 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DIM3 = 3'd7;

   typedef struct packed {
      logic [IDX_W-1:0]  quo;
      logic [SIZE_W-1:0] rem;
   } div_st_type;

   // BITS_PER_STAGE restoring division steps; quotient bits shift into quo
   function automatic div_st_type div_step(input div_st_type s, input logic [SIZE_W-1:0] dvs);
      div_st_type      r;
      logic [SIZE_W:0] part;
      r = s;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
         part  = {r.rem, r.quo[IDX_W-1]};
         r.quo = {r.quo[IDX_W-2:0], 1'b0};
         if (part >= {1'b0, dvs}) begin
            part     = part - {1'b0, dvs};
            r.quo[0] = 1'b1;
         end
         r.rem = part[SIZE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/strided_index_to_offset.sv -----
// Top level of the strided index to offset block.
// Uses sito_pkg for widths, register indexes and the division step.
//
// One offset per cycle while no finished word waits on rsp_: each active
// dimension runs a restoring divider of eight stages, four quotient bits each,
// then one 16x32 multiply stage; the running sum is added at the entry of the
// next dimension and once more at the output register. The whole pipeline
// holds while a finished word waits on rsp_.
// Size registers reading 0 act as 1; indices past the element count wrap at the
// outermost active dimension. Configure only while idle.
module strided_index_to_offset #(
   parameter int NUM_DIMS = sito_pkg::DIMS_MAX
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sito_pkg::IDX_W-1:0]       req_tdata,   // [31:0] linear_index
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sito_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] storage_offset, [32] offset_overflow
   input  logic                             csr_wr_en,
   input  logic [sito_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sito_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ND = (NUM_DIMS > sito_pkg::DIMS_MAX) ? sito_pkg::DIMS_MAX :
                       ((NUM_DIMS < 1) ? 1 : NUM_DIMS);
   localparam int NS = sito_pkg::DIV_STAGES;

   logic [sito_pkg::SIZE_W-1:0] size_ff [sito_pkg::DIMS_MAX];
   logic [sito_pkg::STEP_W-1:0] step_ff [sito_pkg::DIMS_MAX];

   logic                        adv;

   sito_pkg::div_st_type        div_ff  [ND][NS];
   sito_pkg::div_st_type        div_in  [ND][NS];
   logic [sito_pkg::SUM_W-1:0]  sum_ff  [ND][NS];
   logic [sito_pkg::SUM_W-1:0]  sum_in  [ND][NS];
   logic                        vld_ff  [ND][NS];
   logic                        vld_in  [ND][NS];

   logic [sito_pkg::IDX_W-1:0]  mq_ff   [ND];
   logic [sito_pkg::PROD_W-1:0] prod_ff [ND];
   logic [sito_pkg::SUM_W-1:0]  msum_ff [ND];
   logic                        mvld_ff [ND];

   logic [sito_pkg::SUM_W-1:0]  total;
   logic                        rsp_valid_ff;
   logic [sito_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < sito_pkg::DIMS_MAX; d++) begin
            size_ff[d] <= sito_pkg::SIZE_W'(1);
            step_ff[d] <= '0;
         end
         step_ff[sito_pkg::DIMS_MAX-1] <= sito_pkg::STEP_W'(1);
      end else if (csr_wr_en) begin
         if (csr_index < sito_pkg::REG_STEP_DIM0) begin
            size_ff[csr_index[sito_pkg::DIM_SEL_W-1:0]] <= csr_wdata[sito_pkg::SIZE_W-1:0];
         end else begin
            step_ff[csr_index[sito_pkg::DIM_SEL_W-1:0]] <= csr_wdata;
         end
      end
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   genvar k, j;
   generate
      for (k = 0; k < ND; k++) begin : g_dim
         localparam int D = sito_pkg::DIMS_MAX - 1 - k;
         logic [sito_pkg::SIZE_W-1:0] dvs;
         assign dvs = (size_ff[D] == '0) ? sito_pkg::SIZE_W'(1) : size_ff[D];

         for (j = 0; j < NS; j++) begin : g_stage
            sito_pkg::div_st_type src;
            always_comb begin
               if (j == 0) begin
                  if (k == 0) begin
                     src.quo     = req_tdata;
                     src.rem     = '0;
                     sum_in[k][j] = '0;
                     vld_in[k][j] = req_tvalid;
                  end else begin
                     src.quo     = mq_ff[(k == 0) ? 0 : k-1];
                     src.rem     = '0;
                     sum_in[k][j] = msum_ff[(k == 0) ? 0 : k-1]
                                  + {2'b00, prod_ff[(k == 0) ? 0 : k-1]};
                     vld_in[k][j] = mvld_ff[(k == 0) ? 0 : k-1];
                  end
               end else begin
                  src          = div_ff[k][(j == 0) ? 0 : j-1];
                  sum_in[k][j] = sum_ff[k][(j == 0) ? 0 : j-1];
                  vld_in[k][j] = vld_ff[k][(j == 0) ? 0 : j-1];
               end
               div_in[k][j] = sito_pkg::div_step(src, dvs);
            end

            always_ff @(posedge clock) begin
               if (reset) begin
                  vld_ff[k][j] <= 1'b0;
               end else if (adv) begin
                  vld_ff[k][j] <= vld_in[k][j];
               end
               if (adv) begin
                  div_ff[k][j] <= div_in[k][j];
                  sum_ff[k][j] <= sum_in[k][j];
               end
            end
         end

         // coordinate times stride
         always_ff @(posedge clock) begin
            if (reset) begin
               mvld_ff[k] <= 1'b0;
            end else if (adv) begin
               mvld_ff[k] <= vld_ff[k][NS-1];
            end
            if (adv) begin
               mq_ff[k]   <= div_ff[k][NS-1].quo;
               msum_ff[k] <= sum_ff[k][NS-1];
               prod_ff[k] <= sito_pkg::PROD_W'(div_ff[k][NS-1].rem) * sito_pkg::PROD_W'(step_ff[D]);
            end
         end
      end
   endgenerate

   assign total = msum_ff[ND-1] + {2'b00, prod_ff[ND-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mvld_ff[ND-1];
      end
      if (adv) begin
         rsp_data_ff <= {7'b0, (total[sito_pkg::SUM_W-1:32] != '0), total[31:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sim/offset_checker.sv -----
// Checker for the strided index to offset block: watches the req_ and rsp_ words,
// predicts each storage offset from its own copy of sizes and strides.
// Depends on sito_pkg; instantiated beside the block by the testbench top.
module offset_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [sito_pkg::IDX_W-1:0]       req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [sito_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [sito_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sito_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);

   typedef struct packed {
      logic                        ovf;
      logic [sito_pkg::STEP_W-1:0] offset;
   } offset_type;

   logic [sito_pkg::SIZE_W-1:0] dim_size [sito_pkg::DIMS_MAX];
   logic [sito_pkg::STEP_W-1:0] dim_step [sito_pkg::DIMS_MAX];
   offset_type                  offsets_due [$];

   function automatic offset_type calc_offset(input logic [sito_pkg::IDX_W-1:0] lin);
      logic [63:0] rest;
      logic [63:0] total;
      logic [63:0] sz;
      offset_type  o;
      rest  = 64'(lin);
      total = '0;
      for (int k = 0; k < sito_pkg::DIMS_MAX; k++) begin
         sz = 64'(dim_size[sito_pkg::DIMS_MAX-1-k]);
         if (sz == 0) sz = 64'd1;
         total += (rest % sz) * 64'(dim_step[sito_pkg::DIMS_MAX-1-k]);
         rest  = rest / sz;
      end
      o.offset = total[31:0];
      o.ovf    = total[63:32] != '0;
      return o;
   endfunction

   assign pending_count = offsets_due.size();

   always @(posedge clock) begin
      offset_type want, got;
      if (reset) begin
         for (int d = 0; d < sito_pkg::DIMS_MAX; d++) begin
            dim_size[d] <= sito_pkg::SIZE_W'(1);
            dim_step[d] <= '0;
         end
         dim_step[sito_pkg::DIMS_MAX-1] <= sito_pkg::STEP_W'(1);
         offsets_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index < sito_pkg::REG_STEP_DIM0)
               dim_size[csr_index[sito_pkg::DIM_SEL_W-1:0]] <= csr_wdata[sito_pkg::SIZE_W-1:0];
            else
               dim_step[csr_index[sito_pkg::DIM_SEL_W-1:0]] <= csr_wdata;
         end
         if (req_tvalid && req_tready)
            offsets_due.push_back(calc_offset(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[32], rsp_tdata[31:0]};
            if (offsets_due.size() == 0) begin
               $display("%0t: unexpected word, got offset %h ovf %b",
                        $time, got.offset, got.ovf);
               fail_count <= fail_count + 1;
            end else begin
               want = offsets_due.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch, expected offset %h ovf %b, got offset %h ovf %b",
                           $time, want.offset, want.ovf, got.offset, got.ovf);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- sim/testbench.sv -----
// Testbench top for strided_index_to_offset: drives index words and register
// writes under several idle patterns and gives the verdict.
// Depends on sito_pkg, the block and offset_checker.
module testbench;

   localparam int LATENCY    = 40;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_LEN   = 200;

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_tvalid = 0;
   logic                            req_tready;
   logic [sito_pkg::IDX_W-1:0]      req_tdata = 0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 0;
   logic [sito_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_wr_en = 0;
   logic [sito_pkg::CSR_IDX_W-1:0]  csr_index = 0;
   logic [sito_pkg::CSR_DATA_W-1:0] csr_wdata = 0;
   int                              fail_count, pending_count;
   int                              send_idle_pct = 0, recv_idle_pct = 0;
   logic                            hold_req = 0;
   logic                            hold_done = 0;
   int                              hold_cycles = 0;
   int                              quiet_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   strided_index_to_offset dut (.*);

   offset_checker checker_i (.*);

   // receiver: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done   <= 1'b1;
         hold_cycles <= HOLD_LEN;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_index(input logic [sito_pkg::IDX_W-1:0] lin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= lin;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sito_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sito_pkg::CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic set_view(input logic [sito_pkg::SIZE_W-1:0] s0, s1, s2, s3,
                           input logic [sito_pkg::STEP_W-1:0] t0, t1, t2, t3);
      drain();
      write_reg(sito_pkg::REG_SIZE_DIM0, sito_pkg::CSR_DATA_W'(s0));
      write_reg(sito_pkg::REG_SIZE_DIM1, sito_pkg::CSR_DATA_W'(s1));
      write_reg(sito_pkg::REG_SIZE_DIM2, sito_pkg::CSR_DATA_W'(s2));
      write_reg(sito_pkg::REG_SIZE_DIM3, sito_pkg::CSR_DATA_W'(s3));
      write_reg(sito_pkg::REG_STEP_DIM0, t0);
      write_reg(sito_pkg::REG_STEP_DIM1, t1);
      write_reg(sito_pkg::REG_STEP_DIM2, t2);
      write_reg(sito_pkg::REG_STEP_DIM3, t3);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [sito_pkg::SIZE_W-1:0] rand_size;
      case ($urandom_range(3))
         0: return sito_pkg::SIZE_W'($urandom_range(0, 4));
         1: return sito_pkg::SIZE_W'($urandom_range(1, 64));
         2: return 16'hFFFF;
         default: return sito_pkg::SIZE_W'($urandom);
      endcase
   endfunction

   function automatic logic [sito_pkg::STEP_W-1:0] rand_step;
      case ($urandom_range(3))
         0: return '0;
         1: return $urandom_range(1, 1000);
         2: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [sito_pkg::IDX_W-1:0] rand_index;
      case ($urandom_range(2))
         0: return $urandom_range(0, 5000);
         1: return 32'hFFFFFFFF - $urandom_range(0, 50);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset view: all sizes one, so every index maps to offset 0
      send_index(32'd0);
      send_index(32'hFFFFFFFF);
      send_index(32'h5A5A_A5A5);
      // small view, in range, wrap past element count, broadcast dimension
      set_view(16'd2, 16'd3, 16'd4, 16'd5, 32'd60, 32'd0, 32'd5, 32'd1);
      send_index(32'd0);
      send_index(32'd119);
      send_index(32'd120);
      send_index(32'd1000);
      send_index(32'd59);
      // size zero acts as one
      set_view(16'd0, 16'd0, 16'd7, 16'd0, 32'd3, 32'd9, 32'd11, 32'd13);
      send_index(32'd6);
      send_index(32'd7);
      send_index(32'hFFFFFFFF);
      // maximum sizes and strides: overflow
      set_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_index(32'd0);
      send_index(32'd1);
      send_index(32'hFFFFFFFF);
      send_index(32'hFFFEFFFF);
      send_index(32'h8000_0000);
      send_index(32'h0000_FFFF);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 66 : 0;
         recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 30 : 0;
         for (int v = 0; v < 6; v++) begin
            set_view(rand_size(), rand_size(), rand_size(), rand_size(),
                     rand_step(), rand_step(), rand_step(), rand_step());
            if (phase == 2 && v == 0) hold_req <= 1'b1;
            for (int i = 0; i < 36; i++) send_index(rand_index());
         end
      end

      drain();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/sito_pkg.sv
rtl/strided_index_to_offset.sv
sim/offset_checker.sv
sim/testbench.sv
